// ===== design/mcaba_pkg.sv =====
// mcaba_pkg: shared widths, constants and types for the block averager
// no dependencies; imported by mcaba_bank and multichannel_adc_block_averager
`default_nettype none

package mcaba_pkg;

   localparam int SAMPLE_W = 10;
   localparam int BYTE_W   = 8;
   localparam int CHAN_W   = 3;
   localparam int PHASE_W  = 2;
   localparam int SELECT_W = 4;
   localparam int SLOTS    = 3;
   localparam int SUM_W    = BYTE_W + 2;
   localparam int SHIFT    = 2;

   localparam logic [PHASE_W-1:0] PHASE_EMIT = 2'd0;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef byte_type [SLOTS-1:0] row_type;

   typedef struct packed {
      logic                 en;
      logic [CHAN_W-1:0]    chan;
      logic [PHASE_W-1:0]   phase;
      byte_type             data;
   } bank_wr_type;

endpackage

`default_nettype wire

// ===== design/mcaba_bank.sv =====
// mcaba_bank: per-channel phase counters and three stored sample bytes
// depends on mcaba_pkg; instantiated by multichannel_adc_block_averager
`default_nettype none

module mcaba_bank #(
   parameter int NUM_AXES = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [mcaba_pkg::CHAN_W-1:0]    rd_chan,
   input  wire mcaba_pkg::bank_wr_type          wr,
   output      logic [mcaba_pkg::PHASE_W-1:0]   rd_phase,
   output      mcaba_pkg::row_type              rd_row
);
   import mcaba_pkg::*;

   localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   logic [PHASE_W-1:0] phase_ff [NUM_AXES];
   row_type            store_ff [NUM_AXES];

   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;

   assign rd_idx   = rd_chan[IDX_W-1:0];
   assign wr_idx   = wr.chan[IDX_W-1:0];
   assign rd_phase = phase_ff[rd_idx];
   assign rd_row   = store_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            phase_ff[i] <= '0;
            store_ff[i] <= '0;
         end
      end else if (wr.en) begin
         phase_ff[wr_idx] <= wr.phase - PHASE_W'(1);
         if (wr.phase != PHASE_EMIT) begin
            store_ff[wr_idx][wr.phase - PHASE_W'(1)] <= wr.data;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/multichannel_adc_block_averager.sv =====
// multichannel_adc_block_averager: round-robin four-sample boxcar average per channel
// depends on mcaba_pkg and mcaba_bank
//
//   port group   dir  contents
//   req_*        in   one converter sample for the channel under the pointer
//   rsp_*        out  channel, block average and flag, next multiplexer select
//
// one sample per cycle sustained while rsp_tready is high; rsp valid follows the req
// accept through the input register and the result register; the
// phase, store and pointer update happen as a sample leaves the input register
// synchronous active-high reset clears the pointer, all phases and all stores
// rsp_tready low holds the result; the input register still takes one sample
`default_nettype none

module multichannel_adc_block_averager #(
   parameter int NUM_AXES = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [mcaba_pkg::REQ_DATA_W-1:0]    req_tdata,   // [9:0] sample
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [mcaba_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [2:0] channel,
                                                                 // [10:3] average,
                                                                 // [14:11] next_mux_select
   output      logic                                rsp_tuser    // [0] average_ready
);
   import mcaba_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [SAMPLE_W-1:0]   sample_ff;
   logic [CHAN_W-1:0]     channel_ff, channel_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAN_W-1:0]     out_chan_ff;
   logic                  out_ready_ff;
   logic [BYTE_W-1:0]     out_avg_ff;
   logic [SELECT_W-1:0]   out_sel_ff;

   logic                  move;
   logic [PHASE_W-1:0]    phase;
   row_type               row;
   bank_wr_type           wr;
   byte_type              cur_byte;
   logic [SUM_W-1:0]      sum;
   logic [BYTE_W-1:0]     avg;
   logic                  emit;
   logic [CHAN_W-1:0]     next_chan;
   logic [SELECT_W-1:0]   next_sel;

   assign move       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;

   assign cur_byte = sample_ff[SAMPLE_W-1:SAMPLE_W-BYTE_W];
   assign emit     = (phase == PHASE_EMIT);
   assign sum      = SUM_W'(row[0]) + SUM_W'(row[1]) + SUM_W'(row[2]) + SUM_W'(cur_byte);
   assign avg      = emit ? sum[SUM_W-1:SHIFT] : '0;

   assign next_chan = (channel_ff >= CHAN_W'(NUM_AXES - 1)) ? '0 : channel_ff + CHAN_W'(1);
   assign next_sel  = SELECT_W'(next_chan) + SELECT_W'(1);

   assign wr.en    = move;
   assign wr.chan  = channel_ff;
   assign wr.phase = phase;
   assign wr.data  = cur_byte;

   mcaba_bank #(
      .NUM_AXES (NUM_AXES)
   ) u_bank (
      .clock    (clock),
      .reset    (reset),
      .rd_chan  (channel_ff),
      .wr       (wr),
      .rd_phase (phase),
      .rd_row   (row)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      channel_in = move ? next_chan : channel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         channel_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         channel_ff   <= channel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata[SAMPLE_W-1:0];
      end
      if (move) begin
         out_chan_ff  <= channel_ff;
         out_ready_ff <= emit;
         out_avg_ff   <= avg;
         out_sel_ff   <= next_sel;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ready_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SELECT_W - BYTE_W - CHAN_W){1'b0}},
                        out_sel_ff, out_avg_ff, out_chan_ff};

endmodule

`default_nettype wire
